/* src/amdfw_pkg.sv */
// ----------------------------------------------------------------------------
// amdfw_pkg - shared types and constants
// Field widths, operation codes and register indexes of the depth-first walk.
// ----------------------------------------------------------------------------
`default_nettype none

package amdfw_pkg;

    localparam int OP_W       = 2;
    localparam int VNUM_W     = 5;
    localparam int EDGE_IN_W  = 8;
    localparam int START_W    = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD_EDGE  = 2'd0,
        OP_NORMALIZE = 2'd1,
        OP_EXPLORE   = 2'd2,
        OP_CLEAR     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 1'd0,
        CFG_DIRECTED     = 1'd1
    } t_cfg_idx;

endpackage

`default_nettype wire

/* src/amdfw_req_if.sv */
// ----------------------------------------------------------------------------
// amdfw_req_if - request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
`default_nettype none

interface amdfw_req_if;
    logic                                valid;
    logic                                ready;
    amdfw_pkg::t_op                      operation;
    logic [amdfw_pkg::VNUM_W-1:0]        origin;
    logic [amdfw_pkg::VNUM_W-1:0]        destination;
    logic [amdfw_pkg::EDGE_IN_W-1:0]     edge_value;
    logic [amdfw_pkg::START_W-1:0]       start_vertex;

    modport source (
        output valid, operation, origin, destination, edge_value, start_vertex,
        input  ready
    );
    modport sink (
        input  valid, operation, origin, destination, edge_value, start_vertex,
        output ready
    );
endinterface

`default_nettype wire

/* src/amdfw_res_if.sv */
// ----------------------------------------------------------------------------
// amdfw_res_if - result channel
// Valid/ready channel carrying one visited vertex of a walk.
// ----------------------------------------------------------------------------
`default_nettype none

interface amdfw_res_if;
    logic                          valid;
    logic                          ready;
    logic [amdfw_pkg::VNUM_W-1:0]  visited_vertex;
    logic                          last;

    modport source (
        output valid, visited_vertex, last,
        input  ready
    );
    modport sink (
        input  valid, visited_vertex, last,
        output ready
    );
endinterface

`default_nettype wire

/* src/amdfw_ram.sv */
// ----------------------------------------------------------------------------
// amdfw_ram - generic memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module amdfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic [AW-1:0]        i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* src/adjacency_matrix_depth_first_walk.sv */
// ----------------------------------------------------------------------------
// adjacency_matrix_depth_first_walk - depth-first walk over an edge matrix
// Holds an edge matrix and visited marks; adds edges, normalizes, clears
// marks and walks depth first from a start vertex, one result per vertex.
//
//   channel   dir  handshake     payload
//   i_req     in   valid/ready   operation, origin, destination,
//                                edge_value, start_vertex
//   o_res     out  valid/ready   visited_vertex, last
//   i_cfg_*   in   write enable  register index, write data
//
// add edge also writes the mirrored cell when the graph is undirected
// normalize reads and checks each active entry in turn, row by row
// explore scans columns and pops a parent frame on each backtrack, paced by
// the single read port of the matrix memory
// after reset a clearing pass zeroes every cell of the matrix
// a stalled result stalls the walk only when the next vertex must be emitted
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_depth_first_walk #(
    parameter int MAX_VERTICES    = 16,
    parameter int EDGE_VALUE_BITS = 8
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [amdfw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [amdfw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    amdfw_req_if.sink                               i_req,
    amdfw_res_if.source                             o_res
);
    localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int MD  = MAX_VERTICES * MAX_VERTICES;
    localparam int AW  = $clog2(MD);
    localparam int SW  = VW + CW;
    localparam logic [EDGE_VALUE_BITS-1:0] ONE_VAL = EDGE_VALUE_BITS'(1);
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_VERTICES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_MIRROR,
        S_NORM_RD,
        S_NORM_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_WAIT,
        S_FINISH
    } t_state;

    t_state                         r_state;
    logic [amdfw_pkg::VNUM_W-1:0]   r_vertex_count;
    logic                           r_directed;
    logic [MAX_VERTICES-1:0]        r_visited;
    logic [VW-1:0]                  r_cur_v;
    logic [CW-1:0]                  r_col;
    logic [VW-1:0]                  r_depth;
    logic [VW-1:0]                  r_pend;
    logic [VW-1:0]                  r_add_row;
    logic [VW-1:0]                  r_add_col;
    logic [EDGE_VALUE_BITS-1:0]     r_add_val;
    logic                           r_out_valid;
    logic [amdfw_pkg::VNUM_W-1:0]   r_out_vertex;
    logic                           r_out_last;

    logic [CW-1:0]                  active_n;
    logic [CW-1:0]                  active_last;
    logic                           req_fire;
    logic                           add_ok;
    logic                           start_ok;
    logic [VW-1:0]                  org_idx;
    logic [VW-1:0]                  dst_idx;
    logic [EDGE_VALUE_BITS-1:0]     in_val;
    logic                           out_free;
    logic                           out_load;
    logic [VW-1:0]                  col_idx;
    logic                           enter;
    logic [amdfw_pkg::VNUM_W-1:0]   pend_num;

    logic                           mat_we;
    logic [AW-1:0]                  mat_waddr;
    logic [EDGE_VALUE_BITS-1:0]     mat_wdata;
    logic [AW-1:0]                  mat_raddr;
    logic [EDGE_VALUE_BITS-1:0]     mat_rdata;

    logic                           stk_we;
    logic [SW-1:0]                  stk_wdata;
    logic [VW-1:0]                  stk_raddr;
    logic [SW-1:0]                  stk_rdata;

    function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] row,
                                                input logic [VW-1:0] col);
        return AW'(AW'(row) * AW'(MAX_VERTICES) + AW'(col));
    endfunction

    always_comb begin
        if (int'(r_vertex_count) > MAX_VERTICES) begin
            active_n = CW'(MAX_VERTICES);
        end else begin
            active_n = CW'(r_vertex_count);
        end
    end

    assign active_last = active_n - CW'(1);
    assign req_fire    = i_req.valid && i_req.ready;
    assign add_ok      = (i_req.origin != '0) && (i_req.destination != '0) &&
                         (int'(i_req.origin) <= MAX_VERTICES) &&
                         (int'(i_req.destination) <= MAX_VERTICES);
    assign start_ok    = int'(i_req.start_vertex) < MAX_VERTICES;
    assign org_idx     = VW'(i_req.origin - amdfw_pkg::VNUM_W'(1));
    assign dst_idx     = VW'(i_req.destination - amdfw_pkg::VNUM_W'(1));
    assign in_val      = EDGE_VALUE_BITS'(i_req.edge_value);
    assign out_free    = !r_out_valid || o_res.ready;
    assign col_idx     = r_col[VW-1:0];
    assign enter       = !r_visited[col_idx] && (mat_rdata != '0);
    assign pend_num    = amdfw_pkg::VNUM_W'(32'(r_pend) + 1);
    assign out_load    = ((r_state == S_SCAN_CHK) && enter && out_free) ||
                         ((r_state == S_FINISH) && out_free);

    // matrix write port: sweep, edge writes, normalize zeroing
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = cell_addr(r_cur_v, col_idx);
        mat_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mat_we = 1'b1;
            end
            S_IDLE: begin
                mat_we    = req_fire && (i_req.operation == amdfw_pkg::OP_ADD_EDGE) &&
                            add_ok;
                mat_waddr = cell_addr(org_idx, dst_idx);
                mat_wdata = in_val;
            end
            S_ADD_MIRROR: begin
                mat_we    = 1'b1;
                mat_waddr = cell_addr(r_add_col, r_add_row);
                mat_wdata = r_add_val;
            end
            S_NORM_CHK: begin
                mat_we = (mat_rdata != ONE_VAL);
            end
            default: begin
                mat_we = 1'b0;
            end
        endcase
    end

    assign mat_raddr = cell_addr(r_cur_v, col_idx);

    // parent frames; the current frame lives in r_cur_v / r_col
    assign stk_we    = (r_state == S_SCAN_CHK) && enter && out_free;
    assign stk_wdata = {r_cur_v, r_col + CW'(1)};
    assign stk_raddr = r_depth - VW'(1);

    amdfw_ram #(
        .WIDTH (EDGE_VALUE_BITS),
        .DEPTH (MD)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    amdfw_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_VERTICES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_vertex_count <= '0;
            r_directed     <= 1'b0;
            r_visited      <= '0;
            r_cur_v        <= '0;
            r_col          <= '0;
            r_depth        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    amdfw_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                    amdfw_pkg::CFG_DIRECTED:     r_directed     <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_col == LAST_IDX) begin
                        r_col <= '0;
                        if (CW'(r_cur_v) == LAST_IDX) begin
                            r_cur_v <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur_v <= r_cur_v + VW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end

                S_IDLE: begin
                    if (req_fire) begin
                        case (i_req.operation)
                            amdfw_pkg::OP_ADD_EDGE: begin
                                r_add_row <= org_idx;
                                r_add_col <= dst_idx;
                                r_add_val <= in_val;
                                if (add_ok && !r_directed) begin
                                    r_state <= S_ADD_MIRROR;
                                end
                            end
                            amdfw_pkg::OP_NORMALIZE: begin
                                r_cur_v <= '0;
                                r_col   <= '0;
                                if (active_n != '0) begin
                                    r_state <= S_NORM_RD;
                                end
                            end
                            amdfw_pkg::OP_EXPLORE: begin
                                if (start_ok) begin
                                    r_visited[VW'(i_req.start_vertex)] <= 1'b1;
                                    r_pend  <= VW'(i_req.start_vertex);
                                    r_cur_v <= VW'(i_req.start_vertex);
                                    r_col   <= '0;
                                    r_depth <= '0;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            amdfw_pkg::OP_CLEAR: begin
                                r_visited <= '0;
                            end
                            default: ;
                        endcase
                    end
                end

                S_ADD_MIRROR: begin
                    r_state <= S_IDLE;
                end

                S_NORM_RD: begin
                    r_state <= S_NORM_CHK;
                end

                S_NORM_CHK: begin
                    if (r_col == active_last) begin
                        r_col <= '0;
                        if (CW'(r_cur_v) == active_last) begin
                            r_cur_v <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cur_v <= r_cur_v + VW'(1);
                            r_state <= S_NORM_RD;
                        end
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_NORM_RD;
                    end
                end

                S_SCAN_RD: begin
                    if (r_col < active_n) begin
                        r_state <= S_SCAN_CHK;
                    end else if (r_depth == '0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_POP_WAIT;
                    end
                end

                S_SCAN_CHK: begin
                    if (enter) begin
                        // previous vertex goes out, the new one waits for its last flag
                        if (out_free) begin
                            r_out_vertex         <= pend_num;
                            r_out_last           <= 1'b0;
                            r_pend               <= col_idx;
                            r_visited[col_idx]   <= 1'b1;
                            r_depth              <= r_depth + VW'(1);
                            r_cur_v              <= col_idx;
                            r_col                <= '0;
                            r_state              <= S_SCAN_RD;
                        end
                    end else begin
                        r_col   <= r_col + CW'(1);
                        r_state <= S_SCAN_RD;
                    end
                end

                S_POP_WAIT: begin
                    r_cur_v <= stk_rdata[SW-1:CW];
                    r_col   <= stk_rdata[CW-1:0];
                    r_depth <= r_depth - VW'(1);
                    r_state <= S_SCAN_RD;
                end

                S_FINISH: begin
                    if (out_free) begin
                        r_out_vertex <= pend_num;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.visited_vertex = r_out_vertex;
    assign o_res.last           = r_out_last;

endmodule

`default_nettype wire
